>>> design/ptmap_pkg.sv
package ptmap_pkg;

    localparam int TABLE_PAGES_DEF = 64;

    // Table geometry
    localparam int IDX_W   = 9;
    localparam int FRAME_W = 40;
    // Stored entry: frame bits 51:12 above flag bits 2:0, with no other bits
    localparam int ENTRY_W = FRAME_W + 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FRAME_W;
    localparam int ROOT_W     = 6;
    localparam int FIRST_W    = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_PAGE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_NOMEM   = 2'd2,
        ST_OUTSIDE = 2'd3
    } t_status;

    typedef struct packed {
        logic [47:0] virt_addr;
        logic [51:0] dest_addr;
        logic        perm_read;
        logic        perm_write;
        logic        perm_user;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  tables_allocated;
        logic [35:0] invalidate_page;
        logic [52:0] leaf_entry;
    } t_rsp;

    typedef struct packed {
        logic [FRAME_W-1:0] region_base_frame;
        logic [ROOT_W-1:0]  root_page;
        logic               nf_load;
        logic [FIRST_W-1:0] nf_value;
    } t_cfg;

endpackage

>>> design/ptmap_req_if.sv
interface ptmap_req_if;
    logic              valid;
    logic              ready;
    ptmap_pkg::t_req   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ptmap_rsp_if.sv
interface ptmap_rsp_if;
    logic              valid;
    logic              ready;
    ptmap_pkg::t_rsp   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> design/ptmap_store.sv
module ptmap_store #(
    parameter int TABLE_PAGES = ptmap_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1,
    localparam int ADDR_W = PAGE_W + ptmap_pkg::IDX_W
) (
    input  logic                            i_clk,
    input  logic                            i_we,
    input  logic [ADDR_W-1:0]               i_waddr,
    input  logic [ptmap_pkg::ENTRY_W-1:0]   i_wdata,
    input  logic                            i_re,
    input  logic [ADDR_W-1:0]               i_raddr,
    output logic [ptmap_pkg::ENTRY_W-1:0]   o_rd_data
);
    localparam int DEPTH  = TABLE_PAGES * (1 << ptmap_pkg::IDX_W);

    logic [ptmap_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [ptmap_pkg::ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> design/ptmap_walker.sv
module ptmap_walker #(
    parameter int TABLE_PAGES = ptmap_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1,
    localparam int ADDR_W = PAGE_W + ptmap_pkg::IDX_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ptmap_pkg::t_cfg                 i_cfg,
    ptmap_req_if.sink                       i_req,
    ptmap_rsp_if.source                     o_rsp,
    output logic                            o_we,
    output logic [ADDR_W-1:0]               o_waddr,
    output logic [ptmap_pkg::ENTRY_W-1:0]   o_wdata,
    output logic                            o_re,
    output logic [ADDR_W-1:0]               o_raddr,
    input  logic [ptmap_pkg::ENTRY_W-1:0]   i_rd_data
);
    localparam int IDX_W   = ptmap_pkg::IDX_W;
    localparam int FRAME_W = ptmap_pkg::FRAME_W;
    localparam int DEPTH   = TABLE_PAGES * (1 << IDX_W);
    localparam int NF_MIN  = $clog2(TABLE_PAGES + 1);
    localparam int NF_W    = (NF_MIN > ptmap_pkg::FIRST_W) ? NF_MIN : ptmap_pkg::FIRST_W;
    localparam logic [1:0] LAST_LEVEL = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_ZERO,
        S_LINK,
        S_LEAF,
        S_FINISH
    } t_state;

    t_state                 r_state;
    logic [47:0]            r_va;
    logic [51:0]            r_pa;
    logic                   r_user;
    logic                   r_write;
    logic [PAGE_W-1:0]      r_page;
    logic [1:0]             r_level;
    logic [1:0]             r_made;
    ptmap_pkg::t_status     r_status;
    logic [ADDR_W-1:0]      r_slot;
    logic [FRAME_W-1:0]     r_link_frame;
    logic [ADDR_W-1:0]      r_clr_addr;
    logic [NF_W-1:0]        r_next_free;
    logic                   r_rsp_valid;
    ptmap_pkg::t_rsp        r_rsp;

    logic                          req_fire;
    logic                          req_bad;
    logic [IDX_W-1:0]              walk_idx;
    logic [ptmap_pkg::ENTRY_W-1:0] ev_entry;
    logic [FRAME_W:0]              ev_diff;
    logic                          ev_outside;
    logic [PAGE_W-1:0]             ev_page;
    logic                          nf_full;
    logic                          rsp_free;
    logic [ptmap_pkg::ENTRY_W-1:0] leaf_word;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && (r_state == S_IDLE);
    assign req_bad     = (i_req.data.virt_addr == '0) || (i_req.data.dest_addr == '0)
                      || !(i_req.data.perm_read || i_req.data.perm_write
                           || i_req.data.perm_user);

    always_comb begin
        case (r_level)
            2'd0:    walk_idx = r_va[47:39];
            2'd1:    walk_idx = r_va[38:30];
            default: walk_idx = r_va[29:21];
        endcase
    end

    // Freshly linked entries are checked against the region the same way as read ones
    assign ev_entry   = (r_state == S_LINK) ? {r_link_frame, 3'b011} : i_rd_data;
    assign ev_diff    = {1'b0, ev_entry[ptmap_pkg::ENTRY_W-1:3]}
                      - {1'b0, i_cfg.region_base_frame};
    assign ev_outside = ev_diff[FRAME_W] || (ev_diff[FRAME_W-1:0] >= FRAME_W'(TABLE_PAGES));
    assign ev_page    = PAGE_W'(ev_diff[FRAME_W-1:0]);
    assign nf_full    = 32'(r_next_free) >= 32'(TABLE_PAGES);
    assign rsp_free   = !r_rsp_valid || o_rsp.ready;
    assign leaf_word  = {r_pa[51:12], r_user, r_write, 1'b1};

    // Store port
    always_comb begin
        o_we    = 1'b0;
        o_waddr = r_clr_addr;
        o_wdata = '0;
        case (r_state)
            S_CLEAR, S_ZERO: begin
                o_we = 1'b1;
            end
            S_LINK: begin
                o_we    = 1'b1;
                o_waddr = r_slot;
                o_wdata = {r_link_frame, 3'b011};
            end
            S_LEAF: begin
                o_we    = 1'b1;
                o_waddr = {r_page, r_va[20:12]};
                o_wdata = leaf_word;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign o_re    = (r_state == S_READ);
    assign o_raddr = {r_page, walk_idx};

    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= NF_W'(1);
            r_rsp_valid <= 1'b0;
            r_made      <= '0;
            r_level     <= '0;
        end else begin
            if ((r_state == S_FINISH) && rsp_free) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg.nf_load) begin
                r_next_free <= NF_W'(i_cfg.nf_value);
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_fire) begin
                        r_va    <= i_req.data.virt_addr;
                        r_pa    <= i_req.data.dest_addr;
                        r_user  <= i_req.data.perm_user;
                        r_write <= i_req.data.perm_write;
                        r_made  <= '0;
                        r_level <= '0;
                        r_page  <= PAGE_W'(i_cfg.root_page);
                        if (req_bad) begin
                            r_status <= ptmap_pkg::ST_INVALID;
                            r_state  <= S_FINISH;
                        end else if (32'(i_cfg.root_page) >= 32'(TABLE_PAGES)) begin
                            r_status <= ptmap_pkg::ST_OUTSIDE;
                            r_state  <= S_FINISH;
                        end else begin
                            r_status <= ptmap_pkg::ST_OK;
                            r_state  <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_slot  <= o_raddr;
                    r_state <= S_CHECK;
                end
                S_CHECK, S_LINK: begin
                    if ((r_state == S_CHECK) && !i_rd_data[0]) begin
                        // absent: take a page, zero it, then link it; with no page left, finish with NOMEM
                        if (nf_full) begin
                            r_status <= ptmap_pkg::ST_NOMEM;
                            r_state  <= S_FINISH;
                        end else begin
                            r_next_free  <= r_next_free + NF_W'(1);
                            r_made       <= r_made + 2'd1;
                            r_link_frame <= i_cfg.region_base_frame
                                          + FRAME_W'(r_next_free);
                            r_clr_addr   <= {PAGE_W'(r_next_free), IDX_W'(0)};
                            r_state      <= S_ZERO;
                        end
                    end else if (ev_outside) begin
                        r_status <= ptmap_pkg::ST_OUTSIDE;
                        r_state  <= S_FINISH;
                    end else begin
                        r_page <= ev_page;
                        if (r_level == LAST_LEVEL) begin
                            r_state <= S_LEAF;
                        end else begin
                            r_level <= r_level + 2'd1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_ZERO: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr[IDX_W-1:0] == '1) begin
                        r_state <= S_LINK;
                    end
                end
                S_LEAF: begin
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (rsp_free) begin
                        r_rsp.status               <= r_status;
                        r_rsp.tables_allocated     <= r_made;
                        if (r_status == ptmap_pkg::ST_OK) begin
                            r_rsp.invalidate_page  <= r_va[47:12];
                            r_rsp.leaf_entry       <= {1'b0, r_pa[51:12], 9'd0,
                                                       leaf_word[2:0]};
                        end else begin
                            r_rsp.invalidate_page  <= '0;
                            r_rsp.leaf_entry       <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> design/four_level_page_table_mapper_unit.sv
// Each walk reads the table store at three levels and then writes the leaf; an item rejected at
// accept skips the walk, and each table page allocated is first zeroed entry by entry, then linked.
// Throughput: one item at a time, the walk being bound by the three dependent table store reads and
// the leaf write; a result left waiting holds the walker in its last state.
// Reset: the table store is cleared one entry a cycle, with no item accepted meanwhile;
// configuration writes are taken throughout.
module four_level_page_table_mapper_unit #(
    parameter int TABLE_PAGES = ptmap_pkg::TABLE_PAGES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ptmap_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ptmap_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    ptmap_req_if.sink                         i_req,
    ptmap_rsp_if.source                       o_rsp
);
    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int ADDR_W = PAGE_W + ptmap_pkg::IDX_W;

    logic [ptmap_pkg::FRAME_W-1:0] r_region_base_frame;
    logic [ptmap_pkg::ROOT_W-1:0]  r_root_page;
    ptmap_pkg::t_cfg               cfg;

    logic                          st_we;
    logic [ADDR_W-1:0]             st_waddr;
    logic [ptmap_pkg::ENTRY_W-1:0] st_wdata;
    logic                          st_re;
    logic [ADDR_W-1:0]             st_raddr;
    logic [ptmap_pkg::ENTRY_W-1:0] st_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base_frame <= '0;
            r_root_page         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ptmap_pkg::CFG_REGION_BASE: begin
                    r_region_base_frame <= i_cfg_wdata;
                end
                ptmap_pkg::CFG_ROOT_PAGE: begin
                    r_root_page <= i_cfg_wdata[ptmap_pkg::ROOT_W-1:0];
                end
                default: begin
                    r_root_page <= r_root_page;
                end
            endcase
        end
    end

    // First free page is only ever used to load the allocator pointer
    assign cfg.region_base_frame = r_region_base_frame;
    assign cfg.root_page         = r_root_page;
    assign cfg.nf_load           = i_cfg_we && (i_cfg_idx == ptmap_pkg::CFG_FIRST_FREE);
    assign cfg.nf_value          = i_cfg_wdata[ptmap_pkg::FIRST_W-1:0];

    ptmap_walker #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_we      (st_we),
        .o_waddr   (st_waddr),
        .o_wdata   (st_wdata),
        .o_re      (st_re),
        .o_raddr   (st_raddr),
        .i_rd_data (st_rd_data)
    );

    ptmap_store #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (st_we),
        .i_waddr   (st_waddr),
        .i_wdata   (st_wdata),
        .i_re      (st_re),
        .i_raddr   (st_raddr),
        .o_rd_data (st_rd_data)
    );

endmodule
